// File: design/tsm_pkg.sv
package tsm_pkg;

    localparam int FIFO_DEPTH_DEF = 16;
    localparam int Q_DEPTH        = 2;

    typedef struct packed {
        logic               source;
        logic signed [31:0] value;
        logic               ends_sequence;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] merged_value;
        logic               from_source;
        logic               final_res;
        logic               dropped;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DECIDE
    } t_state;

endpackage

// File: design/tsm_front.sv
module tsm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  tsm_pkg::t_in_item i_in_item,
    output logic              o_q_valid,
    input  logic              i_q_take,
    output tsm_pkg::t_in_item o_q_item
);
    import tsm_pkg::*;

    localparam int QPW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCW = $clog2(Q_DEPTH + 1);
    localparam logic [QCW-1:0] Q_FULL = QCW'(Q_DEPTH);
    localparam logic [QPW-1:0] Q_LAST = QPW'(Q_DEPTH - 1);

    t_in_item       r_mem [Q_DEPTH];
    logic [QPW-1:0] r_wp, r_rp;
    logic [QCW-1:0] r_cnt;
    logic           push, pop;

    assign o_in_stall = (r_cnt == Q_FULL);
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_item   = r_mem[r_rp];
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_q_take && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == Q_LAST) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == Q_LAST) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: design/tsm_back.sv
module tsm_back #(
    parameter int FIFO_DEPTH = tsm_pkg::FIFO_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  tsm_pkg::t_in_item  i_q_item,
    output logic               o_q_take,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tsm_pkg::t_out_item o_out_item
);
    import tsm_pkg::*;

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(FIFO_DEPTH);
    localparam logic [CW:0]   DEPTH_W  = (CW+1)'(FIFO_DEPTH);
    localparam logic [PW-1:0] LAST_PTR = PW'(FIFO_DEPTH - 1);

    logic signed [31:0] r_mem1 [FIFO_DEPTH];
    logic signed [31:0] r_mem2 [FIFO_DEPTH];
    logic signed [31:0] r_head1, r_head2;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt1, n_cnt1, r_cnt2, n_cnt2;
    logic [PW-1:0] r_rp1, n_rp1, r_rp2, n_rp2;
    logic          r_end1, n_end1, r_end2, n_end2;
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out_item, n_out_item;

    logic          out_free, drop, wr1, wr2;
    logic [CW:0]   sum1, sum2;
    logic [PW-1:0] wp1, wp2;
    logic          have1, have2, less, emit1, emit2, fin;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign sum1 = (CW+1)'(r_rp1) + (CW+1)'(r_cnt1);
    assign sum2 = (CW+1)'(r_rp2) + (CW+1)'(r_cnt2);
    assign wp1  = (sum1 >= DEPTH_W) ? PW'(sum1 - DEPTH_W) : PW'(sum1);
    assign wp2  = (sum2 >= DEPTH_W) ? PW'(sum2 - DEPTH_W) : PW'(sum2);

    assign drop = i_q_item.source ? (r_cnt2 == DEPTH_C || r_end2)
                                  : (r_cnt1 == DEPTH_C || r_end1);

    assign have1 = (r_cnt1 != '0);
    assign have2 = (r_cnt2 != '0);
    assign less  = (r_head1 < r_head2);
    assign emit1 = (have1 && have2) ? less  : (have1 && r_end2);
    assign emit2 = (have1 && have2) ? !less : (have2 && r_end1);
    assign fin   = r_end1 && r_end2
                && (emit1 ? (r_cnt1 == CW'(1)) : !have1)
                && (emit2 ? (r_cnt2 == CW'(1)) : !have2);

    always_comb begin
        n_state     = r_state;
        n_cnt1      = r_cnt1;
        n_cnt2      = r_cnt2;
        n_rp1       = r_rp1;
        n_rp2       = r_rp2;
        n_end1      = r_end1;
        n_end2      = r_end2;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_item  = r_out_item;
        o_q_take    = 1'b0;
        wr1         = 1'b0;
        wr2         = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid && (out_free || !drop)) begin
                    o_q_take = 1'b1;
                    if (drop) begin
                        n_out_valid             = 1'b1;
                        n_out_item.merged_value = '0;
                        n_out_item.from_source  = i_q_item.source;
                        n_out_item.final_res    = 1'b0;
                        n_out_item.dropped      = 1'b1;
                    end else begin
                        if (i_q_item.source) begin
                            wr2    = 1'b1;
                            n_cnt2 = r_cnt2 + 1'b1;
                            n_end2 = i_q_item.ends_sequence;
                        end else begin
                            wr1    = 1'b1;
                            n_cnt1 = r_cnt1 + 1'b1;
                            n_end1 = i_q_item.ends_sequence;
                        end
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (!(emit1 || emit2)) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out_valid             = 1'b1;
                    n_out_item.merged_value = emit1 ? r_head1 : r_head2;
                    n_out_item.from_source  = !emit1;
                    n_out_item.final_res    = fin;
                    n_out_item.dropped      = 1'b0;
                    if (emit1) begin
                        n_cnt1 = r_cnt1 - 1'b1;
                        n_rp1  = (r_rp1 == LAST_PTR) ? '0 : r_rp1 + 1'b1;
                    end else begin
                        n_cnt2 = r_cnt2 - 1'b1;
                        n_rp2  = (r_rp2 == LAST_PTR) ? '0 : r_rp2 + 1'b1;
                    end
                    if (fin) begin
                        n_end1  = 1'b0;
                        n_end2  = 1'b0;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr1) begin
            r_mem1[wp1] <= i_q_item.value;
        end
        if (wr2) begin
            r_mem2[wp2] <= i_q_item.value;
        end
        r_head1 <= r_mem1[r_rp1];
        r_head2 <= r_mem2[r_rp2];
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt1      <= '0;
            r_cnt2      <= '0;
            r_rp1       <= '0;
            r_rp2       <= '0;
            r_end1      <= 1'b0;
            r_end2      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt1      <= n_cnt1;
            r_cnt2      <= n_cnt2;
            r_rp1       <= n_rp1;
            r_rp2       <= n_rp2;
            r_end1      <= n_end1;
            r_end2      <= n_end2;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: design/two_way_sorted_merge.sv
// Channel  Valid        Stall        Payload
// in       i_in_valid   o_in_stall   i_in_item  (source, value, ends_sequence)
// out      o_out_valid  i_out_stall  o_out_item (merged_value, from_source,
//                                                final_res, dropped)
// A dropped item is answered from the idle state; a stored item passes through the read
// and decide states once and again after each merged result that is not final, the read
// state covering the registered head read of the per-sequence FIFO memories.
// A two-entry input queue keeps taking items while the merge unit works.
// Reset clears counts, pointers, end flags and the queue; FIFO memories are not cleared.
// A stalled output holds in its register; results and drops wait for it to drain.
module two_way_sorted_merge #(
    parameter int FIFO_DEPTH = tsm_pkg::FIFO_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tsm_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tsm_pkg::t_out_item o_out_item
);
    import tsm_pkg::*;

    logic     q_valid, q_take;
    t_in_item q_item;

    tsm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_q_valid  (q_valid),
        .i_q_take   (q_take),
        .o_q_item   (q_item)
    );

    tsm_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_take    (q_take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// File: dv/two_way_sorted_merge_test.sv
module two_way_sorted_merge_test;
    import tsm_pkg::*;

    localparam int DEPTH        = FIFO_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 444;
    localparam int DRAIN_CYCLES = 80;
    localparam int PRINT_CAP    = 40;
    localparam int PREDICTED    = -1;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct {
        t_in_item  item;
        int        n_typed;
        t_out_item exp0;
        t_out_item exp1;
    } t_row;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    int in_idle_pct  = 36;
    int out_idle_pct = 83;

    logic signed [31:0] first_store[$];
    logic signed [31:0] second_store[$];
    logic               first_done;
    logic               second_done;
    t_out_item          step_res[$];
    t_out_item          merged_expect[$];
    t_row               stim_table[$];

    int                 plan_left[2];
    logic signed [31:0] plan_last[2];
    bit                 plan_in_order;

    int errors       = 0;
    int items_sent   = 0;
    int drops_sent   = 0;
    int merges_done  = 0;
    int results_seen = 0;
    t_out_item want_item;

    two_way_sorted_merge uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results still expected", merged_expect.size());
        $display("** two_way_sorted_merge: FAILED **");
        $finish;
    end

    function automatic t_out_item mk_out(input logic signed [31:0] v, input logic src_sel,
                                         input logic fin, input logic drop);
        t_out_item r;
        r = {v, src_sel, fin, drop};
        return r;
    endfunction

    function automatic t_in_item mk_in(input logic src_sel, input logic signed [31:0] v,
                                       input logic ends);
        t_in_item r;
        r = {src_sel, v, ends};
        return r;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        if (errors < PRINT_CAP)
            $display("mismatch on result %0d, %s: got %0d, want %0d",
                     results_seen, field, got, want);
        errors++;
    endtask

    task automatic merge_predict(input t_in_item it);
        logic signed [31:0] v;
        logic               src_sel;
        logic               fin;
        step_res.delete();
        if (it.source == 1'b0 ? (first_store.size() >= DEPTH || first_done)
                              : (second_store.size() >= DEPTH || second_done)) begin
            step_res.push_back(mk_out('0, it.source, 1'b0, 1'b1));
            return;
        end
        if (it.source == 1'b0) begin
            first_store.push_back(it.value);
            first_done = it.ends_sequence;
        end else begin
            second_store.push_back(it.value);
            second_done = it.ends_sequence;
        end
        while (1) begin
            if (first_store.size() > 0 && second_store.size() > 0) begin
                if ($signed(first_store[0]) < $signed(second_store[0])) begin
                    v = first_store.pop_front();
                    src_sel = 1'b0;
                end else begin
                    v = second_store.pop_front();
                    src_sel = 1'b1;
                end
            end else if (first_store.size() > 0 && second_done) begin
                v = first_store.pop_front();
                src_sel = 1'b0;
            end else if (second_store.size() > 0 && first_done) begin
                v = second_store.pop_front();
                src_sel = 1'b1;
            end else begin
                break;
            end
            fin = first_done && second_done && first_store.size() == 0
                  && second_store.size() == 0;
            step_res.push_back(mk_out(v, src_sel, fin, 1'b0));
            if (fin) begin
                first_done  = 1'b0;
                second_done = 1'b0;
                break;
            end
        end
    endtask

    task automatic send_item(input t_in_item it, input int n_typed,
                             input t_out_item t0, input t_out_item t1);
        bit taken;
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end while (!taken);
        merge_predict(it);
        items_sent++;
        foreach (step_res[i]) begin
            if (step_res[i].dropped) drops_sent++;
            if (step_res[i].final_res) merges_done++;
        end
        if (n_typed == PREDICTED) begin
            foreach (step_res[i]) merged_expect.push_back(step_res[i]);
        end else begin
            if (n_typed > 0) merged_expect.push_back(t0);
            if (n_typed > 1) merged_expect.push_back(t1);
        end
    endtask

    task automatic add_row(input t_in_item it, input int n_typed,
                           input t_out_item t0, input t_out_item t1);
        t_row r;
        r.item    = it;
        r.n_typed = n_typed;
        r.exp0    = t0;
        r.exp1    = t1;
        stim_table.push_back(r);
    endtask

    task automatic next_random_item(output t_in_item it);
        logic signed [31:0] base;
        int                 s;
        int                 lens[2];
        if ($urandom_range(99) < 6) begin
            it = mk_in(1'($urandom_range(1)), $urandom, 1'($urandom_range(1)));
            return;
        end
        if (plan_left[0] == 0 && plan_left[1] == 0) begin
            case ($urandom_range(4))
                0: base = $urandom;
                1: base = VAL_MIN;
                2: base = VAL_MAX - 32'sd40;
                default: base = $signed($urandom_range(100)) - 32'sd50;
            endcase
            plan_in_order = ($urandom_range(7) == 0);
            for (int k = 0; k < 2; k++) begin
                lens[k] = plan_in_order ? $urandom_range(10, 20) : $urandom_range(1, 6);
                plan_last[k] = base + $signed($urandom_range(3));
            end
            plan_left[0] = first_done  ? 0 : lens[0];
            plan_left[1] = second_done ? 0 : lens[1];
        end
        if (plan_left[0] == 0)      s = 1;
        else if (plan_left[1] == 0) s = 0;
        else if (plan_in_order)     s = 0;
        else                        s = $urandom_range(1);
        if ($urandom_range(9) == 0) plan_last[s] += $signed($urandom_range(1000, 1));
        else                        plan_last[s] += $signed($urandom_range(3));
        it = mk_in(s[0], plan_last[s], plan_left[s] == 1);
        plan_left[s]--;
    endtask

    always @(posedge clk) begin
        out_stall <= rst_n && ($urandom_range(99) < out_idle_pct);
    end

    always @(negedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (merged_expect.size() == 0) begin
                report_mismatch("unexpected result, merged_value", out_item.merged_value, 0);
            end else begin
                want_item = merged_expect.pop_front();
                if (out_item.merged_value !== want_item.merged_value)
                    report_mismatch("merged_value", out_item.merged_value,
                                    want_item.merged_value);
                if (out_item.from_source !== want_item.from_source)
                    report_mismatch("from_source", out_item.from_source,
                                    want_item.from_source);
                if (out_item.final_res !== want_item.final_res)
                    report_mismatch("final_res", out_item.final_res, want_item.final_res);
                if (out_item.dropped !== want_item.dropped)
                    report_mismatch("dropped", out_item.dropped, want_item.dropped);
            end
            results_seen++;
        end
    end

    initial begin
        t_in_item  it;
        t_out_item none;
        int        random_sent;
        none         = '0;
        first_done   = 1'b0;
        second_done  = 1'b0;
        plan_left[0] = 0;
        plan_left[1] = 0;
        random_sent  = 0;

        // extremes, rearm
        add_row(mk_in(1'b0, VAL_MIN, 1'b1), 0, none, none);
        add_row(mk_in(1'b1, VAL_MAX, 1'b1), 2, mk_out(VAL_MIN, 1'b0, 1'b0, 1'b0),
                mk_out(VAL_MAX, 1'b1, 1'b1, 1'b0));
        // tie goes to the second sequence, item after end is dropped
        add_row(mk_in(1'b0, VAL_MAX, 1'b0), 0, none, none);
        add_row(mk_in(1'b1, VAL_MAX, 1'b1), 2, mk_out(VAL_MAX, 1'b1, 1'b0, 1'b0),
                mk_out(VAL_MAX, 1'b0, 1'b0, 1'b0));
        add_row(mk_in(1'b1, 32'sd7, 1'b0), 1, mk_out('0, 1'b1, 1'b0, 1'b1), none);
        add_row(mk_in(1'b0, VAL_MIN, 1'b1), 1, mk_out(VAL_MIN, 1'b0, 1'b1, 1'b0), none);
        add_row(mk_in(1'b1, -32'sd1, 1'b1), 0, none, none);
        add_row(mk_in(1'b0, -32'sd1, 1'b1), 2, mk_out(-32'sd1, 1'b1, 1'b0, 1'b0),
                mk_out(-32'sd1, 1'b0, 1'b1, 1'b0));
        // fill the first store, overflow it, then flush it in one step
        for (int i = 0; i < DEPTH; i++)
            add_row(mk_in(1'b0, -32'sd100000 + i * 32'sd3571, i == DEPTH - 1),
                    PREDICTED, none, none);
        add_row(mk_in(1'b0, 32'sd0, 1'b0), 1, mk_out('0, 1'b0, 1'b0, 1'b1), none);
        add_row(mk_in(1'b1, 32'sd1000, 1'b1), PREDICTED, none, none);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
            send_item(stim_table[i].item, stim_table[i].n_typed,
                      stim_table[i].exp0, stim_table[i].exp1);

        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent == RANDOM_ITEMS / 3) begin
                in_idle_pct  = 83;
                out_idle_pct = 36;
            end else if (random_sent == 2 * RANDOM_ITEMS / 3) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            next_random_item(it);
            send_item(it, PREDICTED, none, none);
            random_sent++;
        end
        in_valid <= 1'b0;

        while (merged_expect.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d items (%0d dropped), checked %0d results over %0d full merges",
                 items_sent, drops_sent, results_seen, merges_done);
        $display("idle mixes: sender/receiver 36/83, 83/36, 0/0; %0d mismatches", errors);
        if (errors == 0) begin
            $display("** two_way_sorted_merge: PASSED **");
        end else begin
            $display("** two_way_sorted_merge: FAILED **");
        end
        $finish;
    end

endmodule
